### sv/rti_pkg.sv
// shared widths, constants and the divider payload for the ray/triangle test
package rti_pkg;

  localparam int CW    = 24;          // coordinate width
  localparam int FB    = 12;          // coordinate fraction bits
  localparam int EW    = CW + 1;      // edge vector width
  localparam int PW    = 2 * CW + 2;  // cross product component width
  localparam int HW    = 25;          // low part width when splitting a cross component
  localparam int PRW   = 51;          // partial product width
  localparam int DW    = 80;          // dot product width
  localparam int DETW  = 80;          // |det| width in the divider
  localparam int RW    = 100;         // divider remainder width
  localparam int TQ    = CW - 1;      // quotient bits of t
  localparam int UQ    = 17;          // quotient bits of u and v
  localparam int UFRAC = 16;          // fraction bits of u and v
  localparam int MDW   = 40;          // min_det width
  localparam int NF    = 8;           // front stages
  localparam int NDIV  = TQ;          // divider stages
  localparam int NS    = NF + NDIV;   // all stages
  localparam int QBW   = 5;           // quotient bit index width

  localparam logic [TQ-1:0]  DIST_MAX    = '1;
  localparam logic [MDW-1:0] MIN_DET_RST = MDW'(6871948);

  typedef struct packed {
    logic            hit;
    logic            sat;
    logic [DETW-1:0] det;
    logic [RW-1:0]   rem_t;
    logic [RW-1:0]   rem_u;
    logic [RW-1:0]   rem_v;
    logic [TQ-1:0]   q_t;
    logic [UQ-1:0]   q_u;
    logic [UQ-1:0]   q_v;
  } div_pay_t;

  function automatic logic signed [DW-1:0] join_pp(input logic signed [PRW-1:0] h,
                                                   input logic signed [PRW-1:0] l);
    return (DW'(h) <<< HW) + DW'(l);
  endfunction

endpackage

### sv/rti_div_stage.sv
// one restoring divide step for t, u and v, registered
module rti_div_stage import rti_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld,
  input  logic           in_vld,
  input  div_pay_t       in_pay,
  input  logic [QBW-1:0] bit_pos,
  output logic           out_vld,
  output div_pay_t       out_pay
);

  logic          vld_r;
  div_pay_t      pay_r, pay_nxt;
  logic [RW-1:0] dvs;

  always_comb begin
    dvs = {{(RW-DETW){1'b0}}, in_pay.det} << bit_pos;
    pay_nxt = in_pay;
    if (in_pay.rem_t >= dvs) begin
      pay_nxt.rem_t = in_pay.rem_t - dvs;
      pay_nxt.q_t[bit_pos] = 1'b1;
    end
    // u and v only need the low quotient bits
    if (bit_pos < QBW'(UQ)) begin
      if (in_pay.rem_u >= dvs) begin
        pay_nxt.rem_u = in_pay.rem_u - dvs;
        pay_nxt.q_u[bit_pos] = 1'b1;
      end
      if (in_pay.rem_v >= dvs) begin
        pay_nxt.rem_v = in_pay.rem_v - dvs;
        pay_nxt.q_v[bit_pos] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ld) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      pay_r <= pay_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_pay = pay_r;

endmodule

### sv/ray_triangle_intersect_core.sv
// ray/triangle intersection pipeline: exact fixed-point products, then a long divider
//
//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata: ray dir and vertices a, b, c
//  out_    | master    | out_tvalid / out_tready | out_tdata: dist_t, bary_u, bary_v; tuser hit
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_data: min_det
//
// one item per cycle while out_tready keeps up; 8 product/sum stages, then
// 23 divider stages, one quotient bit of t each, u and v in the last 17
// reset clears all valid bits and loads min_det with its default
// each stage holds its item until the next stage frees, so bubbles close up under stall
module ray_triangle_intersect_core import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // dir_x, dir_y, dir_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [12*CW-1:0] in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // dist_t, bary_u, bary_v, zero fill
  output logic [63:0]      out_tdata,
  // hit
  output logic [0:0]       out_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MDW-1:0]   cfg_data
);

  logic [MDW-1:0] min_det_r;
  logic [NF-1:0]  fr_vld_r;
  logic [NDIV-1:0] dv_vld;
  div_pay_t       dv_pay [NDIV];
  logic [NS-1:0]  vld_all, rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r <= MIN_DET_RST;
    end else if (cfg_valid) begin
      min_det_r <= cfg_data;
    end
  end

  assign vld_all = {dv_vld, fr_vld_r};

  always_comb begin
    rdy[NS-1] = !vld_all[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_all[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= '0;
    end else begin
      if (rdy[0]) fr_vld_r[0] <= in_tvalid;
      for (int k = 1; k < NF; k++) begin
        if (rdy[k]) fr_vld_r[k] <= fr_vld_r[k-1];
      end
    end
  end

  // stage 1: fields and edges
  logic signed [CW-1:0] s1_d_r [3], s1_a_r [3];
  logic signed [EW-1:0] s1_e1_r [3], s1_e2_r [3];
  logic signed [CW-1:0] in_d [3], in_a [3], in_b [3], in_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_d[i] = in_tdata[i*CW +: CW];
      in_a[i] = in_tdata[(3+i)*CW +: CW];
      in_b[i] = in_tdata[(6+i)*CW +: CW];
      in_c[i] = in_tdata[(9+i)*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i]  <= in_d[i];
        s1_a_r[i]  <= in_a[i];
        s1_e1_r[i] <= EW'(in_b[i]) - EW'(in_a[i]);
        s1_e2_r[i] <= EW'(in_c[i]) - EW'(in_a[i]);
      end
    end
  end

  // stage 2: products of P = dir x e2
  logic signed [CW-1:0]  s2_d_r [3], s2_a_r [3];
  logic signed [EW-1:0]  s2_e1_r [3], s2_e2_r [3];
  logic signed [PRW-1:0] s2_pa_r [3], s2_pb_r [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_d_r <= s1_d_r; s2_a_r <= s1_a_r; s2_e1_r <= s1_e1_r; s2_e2_r <= s1_e2_r;
      for (int i = 0; i < 3; i++) begin
        s2_pa_r[i] <= PRW'(s1_d_r[(i+1)%3]) * PRW'(s1_e2_r[(i+2)%3]);
        s2_pb_r[i] <= PRW'(s1_d_r[(i+2)%3]) * PRW'(s1_e2_r[(i+1)%3]);
      end
    end
  end

  // stage 3: P
  logic signed [CW-1:0] s3_d_r [3], s3_a_r [3];
  logic signed [EW-1:0] s3_e1_r [3], s3_e2_r [3];
  logic signed [PW-1:0] s3_p_r [3];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_d_r <= s2_d_r; s3_a_r <= s2_a_r; s3_e1_r <= s2_e1_r; s3_e2_r <= s2_e2_r;
      for (int i = 0; i < 3; i++) begin
        s3_p_r[i] <= PW'(s2_pa_r[i] - s2_pb_r[i]);
      end
    end
  end

  // stage 4: split products for det and a.P, products of a x e1
  logic signed [CW-1:0]  s4_d_r [3];
  logic signed [EW-1:0]  s4_e2_r [3];
  logic signed [PRW-1:0] s4_dh_r [3], s4_dl_r [3], s4_uh_r [3], s4_ul_r [3];
  logic signed [PRW-1:0] s4_qa_r [3], s4_qb_r [3];
  logic signed [HW-1:0]  p_hi [3];
  logic signed [HW:0]    p_lo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_hi[i] = s3_p_r[i][PW-1:HW];
      p_lo[i] = {1'b0, s3_p_r[i][HW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_d_r <= s3_d_r; s4_e2_r <= s3_e2_r;
      for (int i = 0; i < 3; i++) begin
        s4_dh_r[i] <= PRW'(s3_e1_r[i]) * PRW'(p_hi[i]);
        s4_dl_r[i] <= PRW'(s3_e1_r[i]) * PRW'(p_lo[i]);
        s4_uh_r[i] <= PRW'(s3_a_r[i]) * PRW'(p_hi[i]);
        s4_ul_r[i] <= PRW'(s3_a_r[i]) * PRW'(p_lo[i]);
        s4_qa_r[i] <= PRW'(s3_a_r[(i+1)%3]) * PRW'(s3_e1_r[(i+2)%3]);
        s4_qb_r[i] <= PRW'(s3_a_r[(i+2)%3]) * PRW'(s3_e1_r[(i+1)%3]);
      end
    end
  end

  // stage 5: det, a.P and Q = a x e1
  logic signed [CW-1:0] s5_d_r [3];
  logic signed [EW-1:0] s5_e2_r [3];
  logic signed [DW-1:0] s5_det_r, s5_ua_r;
  logic signed [PW-1:0] s5_q_r [3];

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_d_r <= s4_d_r; s5_e2_r <= s4_e2_r;
      s5_det_r <= join_pp(s4_dh_r[0], s4_dl_r[0]) + join_pp(s4_dh_r[1], s4_dl_r[1])
                + join_pp(s4_dh_r[2], s4_dl_r[2]);
      s5_ua_r  <= join_pp(s4_uh_r[0], s4_ul_r[0]) + join_pp(s4_uh_r[1], s4_ul_r[1])
                + join_pp(s4_uh_r[2], s4_ul_r[2]);
      for (int i = 0; i < 3; i++) begin
        s5_q_r[i] <= PW'(s4_qa_r[i] - s4_qb_r[i]);
      end
    end
  end

  // stage 6: split products of dir.Q and e2.Q
  logic signed [DW-1:0]  s6_det_r, s6_ua_r;
  logic signed [PRW-1:0] s6_vh_r [3], s6_vl_r [3], s6_th_r [3], s6_tl_r [3];
  logic signed [HW-1:0]  q_hi [3];
  logic signed [HW:0]    q_lo [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_hi[i] = s5_q_r[i][PW-1:HW];
      q_lo[i] = {1'b0, s5_q_r[i][HW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_det_r <= s5_det_r; s6_ua_r <= s5_ua_r;
      for (int i = 0; i < 3; i++) begin
        s6_vh_r[i] <= PRW'(s5_d_r[i]) * PRW'(q_hi[i]);
        s6_vl_r[i] <= PRW'(s5_d_r[i]) * PRW'(q_lo[i]);
        s6_th_r[i] <= PRW'(s5_e2_r[i]) * PRW'(q_hi[i]);
        s6_tl_r[i] <= PRW'(s5_e2_r[i]) * PRW'(q_lo[i]);
      end
    end
  end

  // stage 7: dir.Q and e2.Q
  logic signed [DW-1:0] s7_det_r, s7_ua_r, s7_va_r, s7_ta_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s7_det_r <= s6_det_r; s7_ua_r <= s6_ua_r;
      s7_va_r <= join_pp(s6_vh_r[0], s6_vl_r[0]) + join_pp(s6_vh_r[1], s6_vl_r[1])
               + join_pp(s6_vh_r[2], s6_vl_r[2]);
      s7_ta_r <= join_pp(s6_th_r[0], s6_tl_r[0]) + join_pp(s6_th_r[1], s6_tl_r[1])
               + join_pp(s6_th_r[2], s6_tl_r[2]);
    end
  end

  // stage 8: sign fix, rejection tests, divider setup
  // T is -a for a positive det, so u, v and t all take the opposite sign of det
  div_pay_t             s8_pay_r, s8_nxt;
  logic                 pos;
  logic signed [DW-1:0] det_abs, uu, vv, tt;

  always_comb begin
    pos     = !s7_det_r[DW-1] && (s7_det_r != '0);
    det_abs = pos ? s7_det_r : -s7_det_r;
    uu      = pos ? -s7_ua_r : s7_ua_r;
    vv      = pos ? -s7_va_r : s7_va_r;
    tt      = pos ? -s7_ta_r : s7_ta_r;
    s8_nxt.hit = (det_abs != '0)
              && !($unsigned(det_abs) < DW'(min_det_r))
              && !uu[DW-1] && !(uu > det_abs)
              && !vv[DW-1] && !((uu + vv) > det_abs)
              && !tt[DW-1];
    s8_nxt.sat   = RW'($unsigned(tt)) >= (RW'($unsigned(det_abs)) << (TQ - FB));
    s8_nxt.det   = DETW'($unsigned(det_abs));
    s8_nxt.rem_t = RW'($unsigned(tt)) << FB;
    s8_nxt.rem_u = RW'($unsigned(uu)) << UFRAC;
    s8_nxt.rem_v = RW'($unsigned(vv)) << UFRAC;
    s8_nxt.q_t   = '0;
    s8_nxt.q_u   = '0;
    s8_nxt.q_v   = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s8_pay_r <= s8_nxt;
    end
  end

  // divider, one quotient bit per stage from the top
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    rti_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ld      (rdy[NF+k]),
      .in_vld  ((k == 0) ? fr_vld_r[NF-1] : dv_vld[(k == 0) ? 0 : k-1]),
      .in_pay  ((k == 0) ? s8_pay_r : dv_pay[(k == 0) ? 0 : k-1]),
      .bit_pos (QBW'(TQ - 1 - k)),
      .out_vld (dv_vld[k]),
      .out_pay (dv_pay[k])
    );
  end

  div_pay_t      res;
  logic [TQ-1:0] t_q;
  logic [UQ-1:0] bu, bv;

  assign res        = dv_pay[NDIV-1];
  assign t_q        = !res.hit ? '0 : (res.sat ? DIST_MAX : res.q_t);
  assign bu         = res.hit ? res.q_u : '0;
  assign bv         = res.hit ? res.q_v : '0;
  assign out_tvalid = dv_vld[NDIV-1];
  assign out_tdata  = {{(64-TQ-2*UQ){1'b0}}, bv, bu, t_q};
  assign out_tuser  = res.hit;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("miss item carries nonzero data");
  a_bary_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TQ +: UQ] <= UQ'(65536) && out_tdata[TQ+UQ +: UQ] <= UQ'(65536))
    else $error("barycentric out of range");
  a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
    !fr_vld_r[0] |-> in_tready)
    else $error("input stalled with empty first stage");
`endif

endmodule
